@@ hdl/mie_pkg.sv @@
`timescale 1ns / 1ps
package mie_pkg;
   localparam int AlphabetMaxDefault = 8;
   localparam int CountBitsDefault   = 20;
   localparam int FRAC_BITS          = 16;
   localparam int TOTAL_BITS         = 42;
   localparam int MI_BITS            = 23;
   localparam int ICOUNT_BITS        = 20;
   localparam int PROB_W             = 16;
   localparam int SYM_W              = 3;
   localparam int CSR_ADDR_ALPHABET  = 0;

   typedef struct packed {
      logic [SYM_W-1:0]  symbol;
      logic [PROB_W-1:0] prob_0;
      logic [PROB_W-1:0] prob_1;
      logic [PROB_W-1:0] prob_2;
      logic [PROB_W-1:0] prob_3;
      logic [PROB_W-1:0] prob_4;
      logic [PROB_W-1:0] prob_5;
      logic [PROB_W-1:0] prob_6;
      logic [PROB_W-1:0] prob_7;
      logic              last_item;
   } req_word_type;

   typedef struct packed {
      logic signed [MI_BITS-1:0] mutual_info;
      logic [ICOUNT_BITS-1:0]    item_count;
      logic                      count_overflow;
   } rsp_word_type;

   // lane to merge handshake
   typedef struct packed {
      logic busy;
      logic done;
   } lane_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LOG  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;
endpackage

@@ hdl/mie_log2.sv @@
`timescale 1ns / 1ps
// iterative log2: one squaring per cycle, 16 fraction bits
module mie_log2 import mie_pkg::*; #(
   parameter int VAL_BITS = 19
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [VAL_BITS-1:0]       value,
   output lane_stat_type             stat,
   output logic [FRAC_BITS+5:0]      result
);
   localparam int CNT_W = $clog2(FRAC_BITS + 1);
   logic [31:0]          m_ff, m_in;
   logic [FRAC_BITS-1:0] frac_ff, frac_in;
   logic [5:0]           e_ff, e_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [63:0]          sq;
   logic [33:0]          sqs;
   logic [5:0]           top;
   logic [63:0]          ext;

   always_comb begin
      top = '0;
      for (int i = 0; i < VAL_BITS; i++) begin
         if (value[i]) top = 6'(i);
      end
      ext = 64'(value);
      sq  = 64'(m_ff) * 64'(m_ff);
      sqs = 34'(sq >> 30);
      m_in = m_ff; frac_in = frac_ff; e_in = e_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         e_in = top;
         m_in = 32'((ext << 30) >> top);
         frac_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (sqs[31]) begin
            m_in = 32'(sqs >> 1);
            frac_in = {frac_ff[FRAC_BITS-2:0], 1'b1};
         end else begin
            m_in = 32'(sqs);
            frac_in = {frac_ff[FRAC_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(FRAC_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      m_ff    <= m_in;
      frac_ff <= frac_in;
      e_ff    <= e_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result = {e_ff, frac_ff};
endmodule

@@ hdl/mie_divider.sv @@
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
module mie_divider import mie_pkg::*; #(
   parameter int DEN_BITS = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [TOTAL_BITS-1:0] numer,
   input  logic [DEN_BITS-1:0]   denom,
   output lane_stat_type         stat,
   output logic [TOTAL_BITS-1:0] quot
);
   localparam int CNT_W = $clog2(TOTAL_BITS + 1);
   logic [TOTAL_BITS-1:0] q_ff, q_in;
   logic [DEN_BITS:0]     r_ff, r_in;
   logic [DEN_BITS-1:0]   d_ff, d_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in, done_ff, done_in;
   logic [DEN_BITS+1:0]   trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff, q_ff[TOTAL_BITS-1]};
      if (start) begin
         q_in = numer; r_in = '0; d_in = denom; cnt_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= (DEN_BITS+2)'(d_ff)) begin
            r_in = (DEN_BITS+1)'(trial - (DEN_BITS+2)'(d_ff));
            q_in = {q_ff[TOTAL_BITS-2:0], 1'b1};
         end else begin
            r_in = (DEN_BITS+1)'(trial);
            q_in = {q_ff[TOTAL_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(TOTAL_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot = q_ff;
endmodule

@@ hdl/mutual_information_estimator_unit.sv @@
`timescale 1ns / 1ps
// Mutual information estimator (EXIT chart statistic).
// req_ channel: one word per position, the known symbol, eight Q0.16
// probabilities and last_item. rsp_ channel: one word per block, emitted
// only after a word with last_item set.
// csr_ port: APB-style, register 0 at address 0 = alphabet_bits (k, q=2^k).
// Two log2 lanes run side by side, one on the probability sum and one on
// the symbol's probability; a merge stage subtracts and accumulates.
// Each word occupies the block for a load, 16 squaring steps in the
// log2 lanes and a merge. A last word adds 42 total/count divider steps,
// one to see the divider finish and one to load the output register.
// req_ready is low while a word is in work.
// The result register holds until rsp_ready; while it waits, new words are
// still taken, and the block only stalls its input once the next result is
// ready to load and finds the register still full.
// Reset (synchronous, active high) clears the running total, count,
// overflow flag and sets alphabet_bits to 1.
module mutual_information_estimator_unit import mie_pkg::*; #(
   parameter int ALPHABET_MAX = AlphabetMaxDefault,
   parameter int COUNT_BITS   = CountBitsDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [1:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);
   localparam int PROB_BITS = PROB_W;
   localparam int SUM_BITS = PROB_BITS + 3;
   localparam logic [COUNT_BITS-1:0] CountMax = '1;

   state_type state_ff, state_in;
   logic [1:0]            alpha_ff;
   logic [TOTAL_BITS-1:0] total_ff, total_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  ovf_ff, ovf_in;
   logic                  last_ff, valid_term_ff;
   rsp_word_type          rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SUM_BITS-1:0]   sum;
   logic [PROB_BITS-1:0]  pd;
   logic [PROB_BITS-1:0]  probs [8];
   logic                  accept, start_log, start_div;
   lane_stat_type         st_sum, st_sym, st_div;
   logic [FRAC_BITS+5:0]  l_sum, l_sym;
   logic [FRAC_BITS+5:0]  term;
   logic [TOTAL_BITS:0]   tsum;
   logic [TOTAL_BITS-1:0] quot;
   logic signed [TOTAL_BITS+1:0] mi;
   logic [3:0]            used;

   assign pready = 1'b1;
   assign prdata = {30'd0, alpha_ff};
   always_ff @(posedge clock) begin
      if (reset) alpha_ff <= 2'd1;
      else if (psel && penable && pwrite &&
               paddr == 2'(CSR_ADDR_ALPHABET)) alpha_ff <= pwdata[1:0];
   end

   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      probs[0] = PROB_BITS'(req_data.prob_0); probs[1] = PROB_BITS'(req_data.prob_1);
      probs[2] = PROB_BITS'(req_data.prob_2); probs[3] = PROB_BITS'(req_data.prob_3);
      probs[4] = PROB_BITS'(req_data.prob_4); probs[5] = PROB_BITS'(req_data.prob_5);
      probs[6] = PROB_BITS'(req_data.prob_6); probs[7] = PROB_BITS'(req_data.prob_7);
      used = 4'(1) << alpha_ff;
      if (used > 4'(ALPHABET_MAX)) used = 4'(ALPHABET_MAX);
      sum = '0;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < used) sum = sum + SUM_BITS'(probs[i]);
      end
      pd = probs[req_data.symbol];
   end

   assign start_log = accept;
   assign start_div = (state_ff == ST_LOG) && st_sum.done && last_ff;

   mie_log2 #(.VAL_BITS(SUM_BITS)) u_lane_sum (
      .clock, .reset, .start(start_log), .value(sum), .stat(st_sum), .result(l_sum));
   mie_log2 #(.VAL_BITS(SUM_BITS)) u_lane_sym (
      .clock, .reset, .start(start_log), .value(SUM_BITS'(pd)), .stat(st_sym),
      .result(l_sym));
   // count_in already includes the last word
   mie_divider #(.DEN_BITS(COUNT_BITS)) u_div (
      .clock, .reset, .start(start_div), .numer(total_in), .denom(count_in),
      .stat(st_div), .quot(quot));

   always_comb begin
      term = (l_sum > l_sym) ? l_sum - l_sym : '0;
      tsum = (TOTAL_BITS+1)'(total_ff) + (TOTAL_BITS+1)'(term);
      mi = (TOTAL_BITS+2)'(alpha_ff) <<< FRAC_BITS;
      mi = mi - $signed({2'b00, quot});
      state_in = state_ff; total_in = total_ff; count_in = count_ff; ovf_in = ovf_ff;
      rsp_in = rsp_ff; rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_LOG;
         ST_LOG: if (st_sum.done) begin
            if (valid_term_ff)
               total_in = tsum[TOTAL_BITS] ? '1 : tsum[TOTAL_BITS-1:0];
            if (count_ff == CountMax) ovf_in = 1'b1;
            else count_in = count_ff + 1'b1;
            state_in = last_ff ? ST_DIV : ST_IDLE;
         end
         ST_DIV: if (st_div.done) state_in = ST_OUT;
         // wait here while the previous result is still unread
         ST_OUT: if (!rsp_valid_ff || rsp_ready) begin
            if (mi < -(44'sd4194304)) rsp_in.mutual_info = -23'sd4194304;
            else if (mi > 44'sd4194303) rsp_in.mutual_info = 23'sd4194303;
            else rsp_in.mutual_info = mi[MI_BITS-1:0];
            rsp_in.item_count = ICOUNT_BITS'(count_ff);
            rsp_in.count_overflow = ovf_ff;
            rsp_valid_in = 1'b1;
            total_in = '0; count_in = '0; ovf_in = 1'b0;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         total_ff <= '0; count_ff <= '0; ovf_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in; count_ff <= count_in; ovf_ff <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
      if (accept) begin
         last_ff <= req_data.last_item;
         valid_term_ff <= ({1'b0, req_data.symbol} < used) && (pd != '0);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_lanes_lockstep: assert property (@(posedge clock) disable iff (reset)
      st_sum.done == st_sym.done) else $error("log2 lanes out of step");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      st_sum.busy |-> !req_ready) else $error("accept while lanes busy");
   a_out_after_div: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == ST_OUT) |-> $past(st_div.done)) else $error("output without divide");
endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
   import mie_pkg::*;

   // Cycle budget: about 1300 words, plus the divide for each last word,
   // with sender gaps and receiver stalls; several times over.
   localparam longint CycleLimit = 3000000;
   // A word without last_item produces nothing, so drain waits this long.
   localparam int WordLatency = 80;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_data;
   logic         psel = 1'b0;
   logic         penable = 1'b0;
   logic         pwrite = 1'b0;
   logic [1:0]   paddr = '0;
   logic [31:0]  pwdata = '0;
   logic [31:0]  prdata;
   logic         pready;

   mutual_information_estimator_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // Shadow of the block's state, advanced on each accepted word.
   int unsigned     alpha_k;
   longint unsigned term_sum;
   longint unsigned pos_count;
   bit              ovf_flag;
   rsp_word_type    mi_expected[$];

   int     mismatch_count = 0;
   longint cycle_count = 0;
   int     send_idle_pct = 0;
   int     recv_stall_pct = 0;
   int     hold_request = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   // Fixed-point log2: integer part from top bit, 16 fraction bits by squaring.
   function automatic longint unsigned log2_fixed(longint unsigned v);
      longint unsigned m;
      longint unsigned frac;
      int e;
      frac = 0;
      e = 0;
      if (v == 0) return 0;
      while (e < 63 && (v >> (e + 1)) != 0) e++;
      m = (e <= 30) ? (v << (30 - e)) : (v >> (e - 30));
      for (int i = 0; i < FRAC_BITS; i++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd1 << 31)) begin
            frac = frac | 1;
            m = m >> 1;
         end
      end
      return (longint'(e) << FRAC_BITS) | frac;
   endfunction

   task automatic predict_word(input req_word_type w);
      logic [PROB_W-1:0] probs[8];
      longint unsigned sum;
      longint unsigned ls;
      longint unsigned lp;
      longint unsigned term;
      longint unsigned total_max;
      longint mean;
      longint mi;
      int unsigned used;
      rsp_word_type r;
      probs = '{w.prob_0, w.prob_1, w.prob_2, w.prob_3,
                w.prob_4, w.prob_5, w.prob_6, w.prob_7};
      total_max = (64'd1 << TOTAL_BITS) - 1;
      used = 1 << alpha_k;
      if (used > 8) used = 8;
      sum = 0;
      for (int i = 0; i < used; i++) sum += probs[i];
      if (w.symbol < used && probs[w.symbol] != 0) begin
         ls = log2_fixed(sum);
         lp = log2_fixed(probs[w.symbol]);
         term = (ls > lp) ? ls - lp : 0;
         if (term > total_max - term_sum) term_sum = total_max;
         else term_sum += term;
      end
      if (pos_count >= (64'd1 << ICOUNT_BITS) - 1) ovf_flag = 1'b1;
      else pos_count++;
      if (w.last_item) begin
         mean = longint'(term_sum / pos_count);
         mi = (longint'(alpha_k) << FRAC_BITS) - mean;
         if (mi < -4194304) mi = -4194304;
         if (mi > 4194303) mi = 4194303;
         r.mutual_info = mi[MI_BITS-1:0];
         r.item_count = pos_count[ICOUNT_BITS-1:0];
         r.count_overflow = ovf_flag;
         mi_expected.push_back(r);
         term_sum = 0;
         pos_count = 0;
         ovf_flag = 1'b0;
      end
   endtask

   task automatic report_mismatch(input string what, input longint exp_v, input longint act_v);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("MISMATCH %s: expected %0d, got %0d", what, exp_v, act_v);
   endtask

   // Receiver: random stalls, plus a long hold-off counted down here.
   int hold_left = 0;
   always @(posedge clock) begin
      rsp_word_type e;
      cycle_count <= cycle_count + 1;
      if (rsp_valid && rsp_ready) begin
         if (mi_expected.size() == 0) begin
            report_mismatch("unexpected result", 0, 1);
         end else begin
            e = mi_expected.pop_front();
            if (rsp_data.mutual_info !== e.mutual_info)
               report_mismatch("mutual_info", e.mutual_info, rsp_data.mutual_info);
            if (rsp_data.item_count !== e.item_count)
               report_mismatch("item_count", e.item_count, rsp_data.item_count);
            if (rsp_data.count_overflow !== e.count_overflow)
               report_mismatch("count_overflow", e.count_overflow, rsp_data.count_overflow);
         end
      end
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CycleLimit) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic send_word(input req_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
      predict_word(w);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (mi_expected.size() != 0) @(posedge clock);
      repeat (WordLatency) @(posedge clock);
   endtask

   // Register write then read-back; block must be idle.
   task automatic write_alphabet(input int unsigned k);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= 2'(4 * CSR_ADDR_ALPHABET);
      pwdata <= 32'(k);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      alpha_k = k;
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[1:0] !== 2'(k)) report_mismatch("alphabet_bits readback", k, prdata[1:0]);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [PROB_W-1:0] rand_prob();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return PROB_W'($urandom_range(15));
         3: return PROB_W'($urandom_range(65535, 65000));
         default: return PROB_W'($urandom);
      endcase
   endfunction

   function automatic req_word_type rand_word(input bit last);
      req_word_type w;
      w.symbol = SYM_W'($urandom_range(7));
      // mostly in-range symbols so terms accumulate
      if ($urandom_range(3) != 0) w.symbol = SYM_W'($urandom_range((1 << alpha_k) - 1));
      w.prob_0 = rand_prob();
      w.prob_1 = rand_prob();
      w.prob_2 = rand_prob();
      w.prob_3 = rand_prob();
      w.prob_4 = rand_prob();
      w.prob_5 = rand_prob();
      w.prob_6 = rand_prob();
      w.prob_7 = rand_prob();
      w.last_item = last;
      return w;
   endfunction

   function automatic req_word_type make_word(input int sym, input logic [PROB_W-1:0] p,
                                              input bit last);
      req_word_type w;
      w.symbol = SYM_W'(sym);
      {w.prob_0, w.prob_1, w.prob_2, w.prob_3} = {4{p}};
      {w.prob_4, w.prob_5, w.prob_6, w.prob_7} = {4{p}};
      w.last_item = last;
      return w;
   endfunction

   // Extremes, out-of-range symbol, zero probability, single-word blocks,
   // at every alphabet size including zero bits.
   task automatic test_directed();
      req_word_type w;
      for (int k = 0; k < 4; k++) begin
         write_alphabet(k);
         send_word(make_word(0, '1, 1'b1));
         send_word(make_word(7, 16'h1234, 1'b0));
         w = make_word(1, 16'h0001, 1'b0);
         w.prob_0 = '1;
         send_word(w);
         w = make_word(0, '0, 1'b0);
         w.prob_1 = 16'h8000;
         send_word(w);
         w = make_word((1 << k) - 1, '1, 1'b1);
         w.prob_7 = 16'h0001;
         w.prob_3 = 16'h0001;
         send_word(w);
         wait_drain();
      end
   endtask

   task automatic test_random(input int words);
      for (int n = 0; n < words; n++)
         send_word(rand_word(n == words - 1 || $urandom_range(7) == 0));
      wait_drain();
   endtask

   // Long receiver hold-off while words keep coming, then a full pause.
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_request = 600;
      for (int n = 0; n < 24; n++) send_word(rand_word(n % 3 == 2));
      wait_drain();
      for (int n = 0; n < 12; n++) send_word(rand_word(n % 4 == 3));
      wait_drain();
   endtask

   task automatic test_idle_phases();
      int idle_set[4] = '{0, 64, 0, 33};
      int stall_set[4] = '{0, 0, 64, 33};
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_set[p];
         recv_stall_pct = stall_set[p];
         for (int k = 0; k < 4; k++) begin
            write_alphabet((k + p) % 4);
            test_random(78);
         end
      end
   endtask

   initial begin
      alpha_k = 1;
      term_sum = 0;
      pos_count = 0;
      ovf_flag = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // reset value of alphabet_bits is 1
      send_word(make_word(1, 16'h4000, 1'b1));
      wait_drain();
      test_directed();
      test_backpressure();
      test_idle_phases();
      write_alphabet(3);
      test_backpressure();
      wait_drain();
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && mi_expected.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
